// ----- hw/rtl/cdssd_pkg.sv -----
`default_nettype none

package cdssd_pkg;

   // Request kinds carried on req_tuser
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   // Divisor selection for the digit pipe
   localparam logic [1:0] DIV_10   = 2'd0;
   localparam logic [1:0] DIV_100  = 2'd1;
   localparam logic [1:0] DIV_1000 = 2'd2;

   // Exact reciprocals for 16-bit dividends: q = (v * RCP) >> SHIFT
   localparam logic [16:0] RCP_10   = 17'd52429;  // shift 19
   localparam logic [16:0] RCP_100  = 17'd83887;  // shift 23
   localparam logic [16:0] RCP_1000 = 17'd67109;  // shift 26

   // Reciprocal of ten for quotients below 8192: (q * RCP_Q10) >> 16
   localparam logic [12:0] RCP_Q10 = 13'd6554;

   localparam logic [15:0] SPLIT_VALUE = 16'd1000;
   localparam logic [7:0]  SEG_DP      = 8'h80;

   typedef struct packed {
      logic       valid;
      logic       blank;
      logic       dot;
      logic       line;
      logic [1:0] div_sel;
   } ctrl_type;

   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0: code = 8'd63;
         4'd1: code = 8'd6;
         4'd2: code = 8'd91;
         4'd3: code = 8'd79;
         4'd4: code = 8'd102;
         4'd5: code = 8'd109;
         4'd6: code = 8'd125;
         4'd7: code = 8'd7;
         4'd8: code = 8'd127;
         4'd9: code = 8'd111;
         default: code = 8'd0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cdssd_digit_pipe.sv -----
`default_nettype none

// Three-stage digit extraction: divide, take tens quotient, encode.
module cdssd_digit_pipe (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire cdssd_pkg::ctrl_type ctrl,
   input  wire logic [15:0]        value,
   output logic                    out_valid,
   output logic [7:0]              out_seg,
   output logic                    out_line
);
   import cdssd_pkg::*;

   ctrl_type    c2_ff, c2_in, c3_ff;
   logic [12:0] q2_ff, q2_in;
   logic [12:0] q3_ff;
   logic [9:0]  q10_ff, q10_in;
   logic [16:0] rcp;
   logic [32:0] prod;
   logic [25:0] prod10;
   logic [12:0] times10;
   logic [12:0] rem;
   logic [7:0]  seg_ff, seg_in;
   logic        valid_ff, line_ff;

   // Stage 2: value divided by 10, 100 or 1000
   always_comb begin
      case (ctrl.div_sel)
         DIV_10:   rcp = RCP_10;
         DIV_100:  rcp = RCP_100;
         DIV_1000: rcp = RCP_1000;
         default:  rcp = RCP_10;
      endcase
      prod = 33'(value) * 33'(rcp);
      case (ctrl.div_sel)
         DIV_10:   q2_in = prod[31:19];
         DIV_100:  q2_in = {3'b000, prod[32:23]};
         DIV_1000: q2_in = {6'b000000, prod[32:26]};
         default:  q2_in = prod[31:19];
      endcase
      c2_in = ctrl;
   end

   // Stage 3: quotient divided by ten
   assign prod10 = 26'(q2_ff) * 26'(RCP_Q10);
   assign q10_in = prod10[25:16];

   // Stage 4: remainder and segment code
   always_comb begin
      times10 = {q10_ff, 3'b000} + {2'b00, q10_ff, 1'b0};
      rem     = q3_ff - times10;
      if (c3_ff.blank) begin
         seg_in = 8'h00;
      end else begin
         seg_in = seg_code(rem[3:0]) | (c3_ff.dot ? SEG_DP : 8'h00);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (advance) begin
         c2_ff    <= c2_in;
         c3_ff    <= c2_ff;
         valid_ff <= c3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q2_ff   <= q2_in;
         q3_ff   <= q2_ff;
         q10_ff  <= q10_in;
         seg_ff  <= seg_in;
         line_ff <= c3_ff.line;
      end
   end

   assign out_valid = valid_ff;
   assign out_seg   = seg_ff;
   assign out_line  = line_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/countdown_two_digit_ssd_mux_top.sv -----
// Two-digit multiplexed seven-segment countdown display.
//
// Request channel (req_*): each request is either a load (req_tuser = 1),
// which sets the 16-bit countdown value and returns nothing, or a display
// tick (req_tuser = 0), which flips the active digit, counts down by one
// unless paused, held or already zero, and returns one response.
// Response channel (rsp_*): rsp_tdata is the segment pattern (bit 7 is the
// decimal point, all zero on a tick that finds the count at zero),
// rsp_tuser is the digit line (1 left digit, 0 right digit).
// Path: an accepted tick is registered in c1_ff, c2_ff, c3_ff and then the
// output register. Throughput: one request per cycle while not stalled.
// The count update is finished in the accept cycle; the decimal digit is
// worked out over three further stages (one reciprocal multiply, one
// divide-by-ten multiply, encode).
// Stalls: when the response is not taken, the whole pipe holds and
// req_tready drops in the same cycle; nothing is lost or repeated.
// Reset: synchronous, active high; clears the count, digit select, digit
// line level and all pipe valid bits. A load in flight produces no response.
`default_nettype none

module countdown_two_digit_ssd_mux_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // load_value[15:0], pause_flag[16], hold_flag[17]
   input  wire logic        req_tuser,   // func[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // segments[7:0]
   output logic             rsp_tuser    // digit_line[0]
);
   import cdssd_pkg::*;

   logic [15:0] count_ff, count_in;
   logic        toggle_ff, toggle_in;
   logic        line_ff, line_in;
   ctrl_type    c1_ff, c1_in;
   logic [15:0] v1_ff, v1_in;
   logic        advance;
   logic        accept;
   logic        is_tick;
   logic        pause, hold;
   logic        below_split;

   // Whole pipe moves when the output slot is free or being emptied
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;
   assign is_tick    = (req_tuser == FUNC_TICK);
   assign pause      = req_tdata[16];
   assign hold       = req_tdata[17];

   // Count update and stage-1 control
   always_comb begin
      count_in  = count_ff;
      toggle_in = toggle_ff;
      line_in   = line_ff;
      v1_in     = count_ff;
      c1_in     = '0;
      below_split = 1'b0;
      if (accept) begin
         if (!is_tick) begin
            // load: take the new value, no response
            count_in = req_tdata[15:0];
         end else begin
            toggle_in   = !toggle_ff;
            c1_in.valid = 1'b1;
            if (count_ff == 16'd0) begin
               // blank: keep digit line, no decrement
               c1_in.blank = 1'b1;
               c1_in.line  = line_ff;
            end else begin
               if (!pause && !hold) begin
                  count_in = count_ff - 16'd1;
               end
               v1_in       = count_in;
               line_in     = toggle_in;
               c1_in.line  = toggle_in;
               below_split = (count_in < SPLIT_VALUE);
               c1_in.dot   = below_split && toggle_in;
               if (below_split) begin
                  c1_in.div_sel = toggle_in ? DIV_100 : DIV_10;
               end else begin
                  c1_in.div_sel = toggle_in ? DIV_1000 : DIV_100;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= 16'd0;
         toggle_ff   <= 1'b0;
         line_ff     <= 1'b0;
         c1_ff.valid <= 1'b0;
      end else begin
         count_ff  <= count_in;
         toggle_ff <= toggle_in;
         line_ff   <= line_in;
         if (advance) begin
            c1_ff <= c1_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v1_ff <= v1_in;
      end
   end

   cdssd_digit_pipe u_digit (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctrl      (c1_ff),
      .value     (v1_ff),
      .out_valid (rsp_tvalid),
      .out_seg   (rsp_tdata),
      .out_line  (rsp_tuser)
   );

   // Decimal point is only ever lit on the left digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tuser)
      else $error("decimal point on right digit");

   // A tick at zero count leaves the count at zero
   assert property (@(posedge clock) disable iff (reset)
      accept && is_tick && count_ff == 16'd0 |=> count_ff == 16'd0)
      else $error("count moved away from zero on a tick");

   // A load does not disturb the digit select
   assert property (@(posedge clock) disable iff (reset)
      accept && !is_tick |=> $stable(toggle_ff))
      else $error("digit select changed on a load");

endmodule

`default_nettype wire

// ----- sim/cdssd_display_checker.sv -----
`timescale 1ns / 1ps

module cdssd_display_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,   // load_value[15:0], pause_flag[16], hold_flag[17]
   input  wire logic        req_tuser,   // func[0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,   // segments[7:0]
   input  wire logic        rsp_tuser,   // digit_line[0]
   input  wire logic        drain_done,
   output int               fail_count,
   output int               rsp_seen,
   output logic             check_done
);

   import cdssd_pkg::*;

   typedef struct packed {
      logic [7:0] segments;
      logic       digit_line;
   } glyph_type;

   // Segment patterns for digits 9 down to 0, digit 0 in the low byte
   localparam logic [79:0] GLYPHS = {8'd111, 8'd127, 8'd7, 8'd125, 8'd109,
                                     8'd102, 8'd79, 8'd91, 8'd6, 8'd63};

   logic [15:0] count_q;
   logic        toggle_q;
   logic        line_q;
   glyph_type   pending_glyphs[$];
   int          errors = 0;

   function automatic logic [7:0] glyph_of(input int unsigned quotient);
      return GLYPHS[(quotient % 10) * 8 +: 8];
   endfunction

   task automatic flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   // Advance the display state by one tick and queue the response it shows
   task automatic advance_tick(input logic pause, input logic hold);
      glyph_type g;
      toggle_q = ~toggle_q;
      if (count_q == 16'd0) begin
         // blank, digit line keeps its last level
         g.segments   = 8'h00;
         g.digit_line = line_q;
      end else begin
         if (!pause && !hold)
            count_q = count_q - 16'd1;
         line_q       = toggle_q;
         g.digit_line = line_q;
         if (count_q < SPLIT_VALUE)
            g.segments = toggle_q ? (glyph_of(count_q / 100) | SEG_DP)
                                  : glyph_of(count_q / 10);
         else
            g.segments = toggle_q ? glyph_of(count_q / 1000) : glyph_of(count_q / 100);
      end
      pending_glyphs.push_back(g);
   endtask

   always @(posedge clock) begin
      glyph_type want;
      if (reset) begin
         count_q  = '0;
         toggle_q = 1'b0;
         line_q   = 1'b0;
         pending_glyphs.delete();
         rsp_seen   <= 0;
         check_done <= 1'b0;
         fail_count <= errors;
      end else begin
         // responses trail their requests, so compare before predicting
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen <= rsp_seen + 1;
            if (pending_glyphs.size() == 0) begin
               flag_mismatch($sformatf("response %0d with none expected: seg=%02h line=%b",
                                       rsp_seen, rsp_tdata, rsp_tuser));
            end else begin
               want = pending_glyphs.pop_front();
               if (rsp_tdata !== want.segments)
                  flag_mismatch($sformatf("response %0d segments %02h, want %02h",
                                          rsp_seen, rsp_tdata, want.segments));
               if (rsp_tuser !== want.digit_line)
                  flag_mismatch($sformatf("response %0d digit_line %b, want %b",
                                          rsp_seen, rsp_tuser, want.digit_line));
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_LOAD)
               count_q = req_tdata[15:0];
            else
               advance_tick(req_tdata[16], req_tdata[17]);
         end
         if (drain_done && !check_done) begin
            if (pending_glyphs.size() != 0)
               flag_mismatch($sformatf("%0d expected responses never arrived",
                                       pending_glyphs.size()));
            check_done <= 1'b1;
         end
         fail_count <= errors;
      end
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   import cdssd_pkg::*;

   localparam int RESET_CYCLES  = 7;
   localparam int PHASE_ITEMS   = 300;   // three phases, about 900 random requests
   localparam int DRAIN_CYCLES  = 16;    // pipe is four deep, allow plenty beyond it
   localparam int STALL_LIMIT   = 2000;  // cycles without any handshake

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;         // load_value[15:0], pause_flag[16], hold_flag[17]
   logic        req_tuser  = FUNC_TICK;  // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;               // segments[7:0]
   logic        rsp_tuser;               // digit_line[0]
   logic        drain_done = 1'b0;

   int   fail_count;
   int   rsp_seen;
   logic check_done;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int loads_sent     = 0;
   int ticks_sent     = 0;
   int idle_cycles    = 0;

   countdown_two_digit_ssd_mux_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Watch both channels, predict every tick and compare the responses
   cdssd_display_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .drain_done (drain_done),
      .fail_count (fail_count),
      .rsp_seen   (rsp_seen),
      .check_done (check_done)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: drop tready at random with the current stall rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("** countdown_two_digit_ssd_mux_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Drive one request, with random idle cycles ahead of it, and hold it
   // until the block takes it. tvalid gets at most one assignment per edge.
   task automatic push_request(input logic func, input logic [15:0] value,
                               input logic pause, input logic hold);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'b0, hold, pause, value};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (func == FUNC_LOAD)
         loads_sent++;
      else
         ticks_sent++;
   endtask

   // Hold off the sender until every tick sent so far has been answered
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rsp_seen < ticks_sent)
         @(posedge clock);
   endtask

   // Favor small values (to reach zero and blanking) and values around the
   // 1000 split; the rest are 0 or FFFF, or cover the whole 16-bit range
   function automatic logic [15:0] pick_load_value();
      case ($urandom_range(9))
         0, 1, 2: return 16'($urandom_range(40));
         3, 4:    return 16'($urandom_range(1012, 990));
         5:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(input int items, input int send_pct, input int stall_pct);
      int sent;
      int burst;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(19))
            0: begin
               // stray tick, flags and unused value bits at random
               push_request(FUNC_TICK, 16'($urandom), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
               sent++;
            end
            1: begin
               // back-to-back loads: only the last one should stick
               push_request(FUNC_LOAD, 16'($urandom), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
               push_request(FUNC_LOAD, pick_load_value(), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
               sent += 2;
            end
            default: begin
               // load a value, then a burst of ticks counting it down
               push_request(FUNC_LOAD, pick_load_value(), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
               sent++;
               burst = $urandom_range(30, 1);
               repeat (burst) begin
                  push_request(FUNC_TICK, 16'($urandom), $urandom_range(99) < 15,
                               $urandom_range(99) < 15);
                  sent++;
               end
            end
         endcase
         if ($urandom_range(49) == 0)
            wait_for_responses();
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: ticks straight out of reset show blank with the line low
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'hFFFF, 1'b1, 1'b1);
      // top of the range; flags on a load are ignored
      push_request(FUNC_LOAD, 16'hFFFF, 1'b1, 1'b1);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b1, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b1);
      push_request(FUNC_TICK, 16'h0000, 1'b1, 1'b1);
      // crossing the split: 1000 counts down to 999 and gains the dot
      push_request(FUNC_LOAD, 16'd1000, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      // held exactly at the split
      push_request(FUNC_LOAD, 16'd1000, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b1);
      // count reaches zero: zero is shown once, then the display blanks
      push_request(FUNC_LOAD, 16'd2, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      // explicit zero load blanks at once
      push_request(FUNC_LOAD, 16'd0, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      // just above the split
      push_request(FUNC_LOAD, 16'd1001, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      push_request(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      wait_for_responses();

      // Random: idle-heavy receiver, then idle-heavy sender, then full rate
      run_phase(PHASE_ITEMS, 7, 52);
      wait_for_responses();
      run_phase(PHASE_ITEMS, 52, 7);
      run_phase(PHASE_ITEMS, 0, 0);

      // Drain: wait out every response, let the pipe settle, then close out
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      drain_done <= 1'b1;
      @(posedge clock);
      while (!check_done)
         @(posedge clock);

      $display("Run covered %0d loads and %0d ticks; %0d responses compared.",
               loads_sent, ticks_sent, rsp_seen);
      $display("Directed corner cases, then three sender/receiver idle profiles.");
      if (fail_count == 0) begin
         $display("** countdown_two_digit_ssd_mux_top: PASSED **");
      end else begin
         $display("** countdown_two_digit_ssd_mux_top: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/cdssd_pkg.sv
hw/rtl/cdssd_digit_pipe.sv
hw/rtl/countdown_two_digit_ssd_mux_top.sv
sim/cdssd_display_checker.sv
sim/tb_top.sv
